>>> hdl/sactl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sactl_pkg: shared definitions for the cache tag lookup
// Geometry constants, register codes, metadata row layout and helpers used
// by the tag lookup top level and its replacement unit.
// ----------------------------------------------------------------------------
package sactl_pkg;

   localparam int WAYS       = 8;
   localparam int SET_COUNT  = 64;
   localparam int ADDR_BITS  = 48;
   localparam int WAY_BITS   = $clog2(WAYS);
   localparam int SET_BITS   = $clog2(SET_COUNT);
   localparam int OFF_BITS   = 3;
   localparam int TAG_BITS   = ADDR_BITS - SET_BITS;
   localparam int TREE_BITS  = WAYS - 1;
   localparam int NODE_BITS  = WAY_BITS;
   localparam int LFSR_BITS  = 16;
   localparam int COUNT_BITS = 32;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 8;
   localparam int TAG_ADDR_BITS = SET_BITS + WAY_BITS;

   localparam logic [LFSR_BITS-1:0]  LFSR_TAPS = 16'hB400;
   localparam logic [LFSR_BITS-1:0]  LFSR_SEED = 16'h0001;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Replacement mode codes.
   localparam logic [1:0] REPL_LRU    = 2'd0;
   localparam logic [1:0] REPL_RANDOM = 2'd1;
   localparam logic [1:0] REPL_TREE   = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALLOC  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OFFSET = 2'd2;

   localparam logic [1:0]          MODE_RESET   = REPL_LRU;
   localparam logic                ALLOC_RESET  = 1'b1;
   localparam logic [OFF_BITS-1:0] OFFSET_RESET = 3'd6;

   typedef logic [WAY_BITS-1:0] way_type;

   // One row of per-set metadata: valid bits, recency order (position 0 is
   // most recent) and tree pseudo-LRU node bits.
   typedef struct packed {
      logic [WAYS-1:0]      valid;
      way_type [WAYS-1:0]   order;
      logic [TREE_BITS-1:0] tree;
   } meta_type;

   localparam int META_BITS = $bits(meta_type);

   typedef struct packed {
      way_type  way;
      logic     filled;
      logic     lfsr_step;
      meta_type meta;
   } repl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // Contents of a row that has never been written.
   function automatic meta_type meta_reset();
      meta_type m;
      m.valid = '0;
      m.tree  = '0;
      for (int i = 0; i < WAYS; i++) begin
         m.order[i] = WAY_BITS'(i);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

>>> hdl/set_assoc_cache_tag_lookup_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_top: set-associative cache tag lookup
// Tag compare, hit/miss report, line fill with selectable replacement and
// saturating hit and miss totals.
// ----------------------------------------------------------------------------
// An access passes through the states idle, read, scan and update: idle accepts
// it, read fetches the set's metadata row and first tag, scan compares the ways
// in turn with the single tag comparator (stopping at the first hit, or after
// the last of the WAYS ways), and update writes the tag and metadata RAMs and
// loads the result register.
// The update cycle waits while an earlier result is still held on the result
// channel. A new access is accepted while a result waits, and no further
// access is taken until the block returns to idle. Tags live in a RAM
// addressed by set and way; valid bits, recency order and tree bits live in a
// per-set RAM, and a row never written reads as its reset value, so there is
// no clearing pass after reset.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_top import sactl_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_op,
   input  wire logic [ADDR_BITS-1:0]     req_address,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_hit,
   output logic [2:0]                    rsp_way,
   output logic                          rsp_filled,
   output logic [COUNT_BITS-1:0]         rsp_hit_total,
   output logic [COUNT_BITS-1:0]         rsp_miss_total,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [1:0]           mode_ff;
   logic                 alloc_ff;
   logic [OFF_BITS-1:0]  offset_ff;

   logic                 op_ff;
   logic [SET_BITS-1:0]  set_ff;
   logic [TAG_BITS-1:0]  tag_ff;
   way_type              way_cnt_ff;
   logic                 hit_ff;
   way_type              hit_way_ff;
   logic [LFSR_BITS-1:0] lfsr_ff;
   logic [COUNT_BITS-1:0] hit_cnt_ff, hit_cnt_in;
   logic [COUNT_BITS-1:0] miss_cnt_ff, miss_cnt_in;
   logic [SET_COUNT-1:0] row_init_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [2:0]           rsp_way_ff;
   logic                 rsp_filled_ff;
   logic [COUNT_BITS-1:0] rsp_hit_total_ff;
   logic [COUNT_BITS-1:0] rsp_miss_total_ff;

   logic                 accept;
   logic [ADDR_BITS-1:0] shifted;
   logic                 hit_now;
   logic                 last_way;
   logic                 proceed;

   logic                 meta_rd_en;
   logic                 tag_rd_en;
   way_type              tag_rd_way;
   logic                 update_en;
   logic [META_BITS-1:0] meta_rdata;
   logic [TAG_BITS-1:0]  tag_rdata;
   meta_type             meta_cur;
   logic                 alloc_en;
   logic [LFSR_BITS-1:0] lfsr_next;
   repl_type             repl;

   function automatic logic [ADDR_BITS-1:0] req_offset_amount(logic [OFF_BITS-1:0] off);
      return ADDR_BITS'(off);
   endfunction

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign shifted   = req_address >> req_offset_amount(offset_ff);

   assign meta_cur = row_init_ff[set_ff] ? meta_type'(meta_rdata) : meta_reset();
   assign hit_now  = meta_cur.valid[way_cnt_ff] && (tag_rdata == tag_ff);
   assign last_way = (way_cnt_ff == WAY_BITS'(WAYS - 1));
   assign proceed  = !rsp_valid_ff || !rsp_stall;
   assign alloc_en = !hit_ff && (!op_ff || alloc_ff);

   sactl_ram #(
      .WIDTH (META_BITS),
      .DEPTH (SET_COUNT)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (update_en),
      .wr_addr (set_ff),
      .wr_data (META_BITS'(repl.meta)),
      .rd_en   (meta_rd_en),
      .rd_addr (set_ff),
      .rd_data (meta_rdata)
   );

   sactl_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (SET_COUNT * WAYS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (update_en && repl.filled),
      .wr_addr ({set_ff, repl.way}),
      .wr_data (tag_ff),
      .rd_en   (tag_rd_en),
      .rd_addr ({set_ff, tag_rd_way}),
      .rd_data (tag_rdata)
   );

   sactl_repl u_repl (
      .meta_in   (meta_cur),
      .hit       (hit_ff),
      .hit_way   (hit_way_ff),
      .alloc_en  (alloc_en),
      .mode      (mode_ff),
      .lfsr      (lfsr_ff),
      .lfsr_next (lfsr_next),
      .result    (repl)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_READ;
         ST_READ:   state_in = ST_SCAN;
         ST_SCAN:   if (hit_now || last_way) state_in = ST_UPDATE;
         ST_UPDATE: if (proceed) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State machine outputs.
   always_comb begin
      meta_rd_en = 1'b0;
      tag_rd_en  = 1'b0;
      tag_rd_way = '0;
      update_en  = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_READ: begin
            meta_rd_en = 1'b1;
            tag_rd_en  = 1'b1;
         end
         ST_SCAN: begin
            tag_rd_en  = !hit_now && !last_way;
            tag_rd_way = way_cnt_ff + 1'b1;
         end
         ST_UPDATE: update_en = proceed;
         default: ;
      endcase
   end

   always_comb begin
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      if (hit_ff) begin
         if (hit_cnt_ff != COUNT_MAX) hit_cnt_in = hit_cnt_ff + 1'b1;
      end else begin
         if (miss_cnt_ff != COUNT_MAX) miss_cnt_in = miss_cnt_ff + 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RESET;
         alloc_ff     <= ALLOC_RESET;
         offset_ff    <= OFFSET_RESET;
         lfsr_ff      <= LFSR_SEED;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         row_init_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MODE:   mode_ff   <= csr_wdata[1:0];
               CSR_ALLOC:  alloc_ff  <= csr_wdata[0];
               CSR_OFFSET: offset_ff <= csr_wdata[OFF_BITS-1:0];
               default: ;
            endcase
         end
         if (update_en) begin
            hit_cnt_ff          <= hit_cnt_in;
            miss_cnt_ff         <= miss_cnt_in;
            row_init_ff[set_ff] <= 1'b1;
            if (repl.lfsr_step) lfsr_ff <= lfsr_next;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Transaction payload and per-access working registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_op;
         set_ff <= shifted[SET_BITS-1:0];
         tag_ff <= TAG_BITS'(shifted >> SET_BITS);
      end
      if (state_ff == ST_READ) begin
         way_cnt_ff <= '0;
         hit_ff     <= 1'b0;
         hit_way_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         if (hit_now) begin
            hit_ff     <= 1'b1;
            hit_way_ff <= way_cnt_ff;
         end else if (!last_way) begin
            way_cnt_ff <= way_cnt_ff + 1'b1;
         end
      end
      if (update_en) begin
         rsp_hit_ff        <= hit_ff;
         rsp_way_ff        <= 3'(repl.way);
         rsp_filled_ff     <= repl.filled;
         rsp_hit_total_ff  <= hit_cnt_in;
         rsp_miss_total_ff <= miss_cnt_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_way        = rsp_way_ff;
   assign rsp_filled     = rsp_filled_ff;
   assign rsp_hit_total  = rsp_hit_total_ff;
   assign rsp_miss_total = rsp_miss_total_ff;

endmodule
`default_nettype wire

>>> hdl/sactl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sactl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds until the
// next read enable.
// ----------------------------------------------------------------------------
module sactl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/sactl_repl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sactl_repl: way selection and replacement bookkeeping
// Picks the way for a hit or fill (free way, LRU, random or tree victim) and
// produces the updated metadata row for the set.
// ----------------------------------------------------------------------------
module sactl_repl import sactl_pkg::*; (
   input  wire meta_type             meta_in,
   input  wire logic                 hit,
   input  wire way_type              hit_way,
   input  wire logic                 alloc_en,
   input  wire logic [1:0]           mode,
   input  wire logic [LFSR_BITS-1:0] lfsr,
   output logic [LFSR_BITS-1:0]      lfsr_next,
   output repl_type                  result
);

   logic    free_found;
   way_type free_way;
   way_type tree_way;
   way_type victim_way;
   way_type sel_way;
   logic    touch_en;
   logic    fill;
   meta_type meta_out;

   // Walk the tree: a clear node bit sends the walk to the lower half.
   function automatic way_type walk_tree(logic [TREE_BITS-1:0] bits);
      int lo;
      int hi;
      int mid;
      int node;
      lo   = 0;
      hi   = WAYS;
      node = 0;
      for (int k = 0; k < WAY_BITS; k++) begin
         if (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (node < TREE_BITS && !bits[NODE_BITS'(node)]) begin
               node = 2 * node + 1;
               hi   = mid;
            end else begin
               node = 2 * node + 2;
               lo   = mid;
            end
         end
      end
      return WAY_BITS'(lo);
   endfunction

   // Point the tree nodes on the path of way w away from it.
   function automatic logic [TREE_BITS-1:0] mark_tree(logic [TREE_BITS-1:0] bits,
                                                      way_type w);
      logic [TREE_BITS-1:0] t;
      int lo;
      int hi;
      int mid;
      int node;
      t    = bits;
      lo   = 0;
      hi   = WAYS;
      node = 0;
      for (int k = 0; k < WAY_BITS; k++) begin
         if (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (int'(w) < mid) begin
               if (node < TREE_BITS) t[NODE_BITS'(node)] = 1'b1;
               node = 2 * node + 1;
               hi   = mid;
            end else begin
               if (node < TREE_BITS) t[NODE_BITS'(node)] = 1'b0;
               node = 2 * node + 2;
               lo   = mid;
            end
         end
      end
      return t;
   endfunction

   always_comb begin
      free_found = 1'b0;
      free_way   = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (!meta_in.valid[i]) begin
            free_found = 1'b1;
            free_way   = WAY_BITS'(i);
         end
      end
   end

   assign lfsr_next = {1'b0, lfsr[LFSR_BITS-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);
   assign tree_way  = walk_tree(meta_in.tree);

   always_comb begin
      case (mode)
         REPL_RANDOM: victim_way = lfsr_next[WAY_BITS-1:0];
         REPL_TREE:   victim_way = tree_way;
         default:     victim_way = meta_in.order[WAYS-1];
      endcase
   end

   assign fill     = !hit && alloc_en;
   assign touch_en = hit || alloc_en;
   assign sel_way  = hit ? hit_way : (free_found ? free_way : victim_way);

   // Move the selected way to the top of the recency order.
   always_comb begin
      int pos;
      pos = WAYS - 1;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (meta_in.order[i] == sel_way) pos = i;
      end
      meta_out = meta_in;
      if (touch_en) begin
         meta_out.order[0] = sel_way;
         for (int i = 1; i < WAYS; i++) begin
            if (i <= pos) meta_out.order[i] = meta_in.order[i-1];
         end
         meta_out.tree           = mark_tree(meta_in.tree, sel_way);
         meta_out.valid[sel_way] = 1'b1;
      end
   end

   always_comb begin
      result.way       = touch_en ? sel_way : '0;
      result.filled    = fill;
      result.lfsr_step = fill && !free_found && (mode == REPL_RANDOM);
      result.meta      = meta_out;
   end

endmodule
`default_nettype wire
